/* sv/ring_fifo_with_watermark_minmax_core_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the ring FIFO core
// Immediate-implication and next-cycle-implication property wrappers.
// ---------------------------------------------------------------------------
`ifndef RING_FIFO_WITH_WATERMARK_MINMAX_CORE_ASSERT_SVH
`define RING_FIFO_WITH_WATERMARK_MINMAX_CORE_ASSERT_SVH

// same-cycle implication
`define RFWM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RFWM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/rfwm_pkg.sv */
// ---------------------------------------------------------------------------
// Ring FIFO package
// Shared widths, codes and transaction types of the ring FIFO core.
// ---------------------------------------------------------------------------
package rfwm_pkg;

    localparam int RFWM_WORD_BITS = 32;
    localparam int RFWM_FILL_BITS = 7;
    localparam int RFWM_FILL_MAX  = (1 << RFWM_FILL_BITS) - 1;
    localparam int RFWM_DEPTH_DEF = 64;
    localparam int RFWM_ADDR_BITS = 3;
    localparam int RFWM_DATA_BITS = 32;

    localparam logic [RFWM_FILL_BITS-1:0] LIMIT_RESET = 7'd50;

    localparam logic [1:0] ACT_PUSH  = 2'd0;
    localparam logic [1:0] ACT_POP_A = 2'd1;
    localparam logic [1:0] ACT_POP_B = 2'd2;

    localparam logic [1:0] ST_PUSHED  = 2'd0;
    localparam logic [1:0] ST_DROPPED = 2'd1;
    localparam logic [1:0] ST_POPPED  = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    typedef struct packed {
        logic [1:0]                       action;
        logic signed [RFWM_WORD_BITS-1:0] push_value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]                       status;
        logic signed [RFWM_WORD_BITS-1:0] pop_value;
        logic [RFWM_FILL_BITS-1:0]        occupancy;
        logic [RFWM_FILL_BITS-1:0]        high_water;
        logic signed [RFWM_WORD_BITS-1:0] reader_min;
        logic signed [RFWM_WORD_BITS-1:0] reader_max;
        logic                             reader_has_value;
    } t_out_item;

    typedef struct packed {
        logic                             upd;
        logic                             is_b;
        logic signed [RFWM_WORD_BITS-1:0] value;
    } t_stat_req;

    typedef struct packed {
        logic signed [RFWM_WORD_BITS-1:0] min_val;
        logic signed [RFWM_WORD_BITS-1:0] max_val;
        logic                             seen;
    } t_stat_rsp;

endpackage

/* sv/rfwm_cfg.sv */
// ---------------------------------------------------------------------------
// Ring FIFO configuration register
// APB-style slave holding the buffer limit register.
// ---------------------------------------------------------------------------
module rfwm_cfg (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [rfwm_pkg::RFWM_ADDR_BITS-1:0]   paddr,
    input  logic [rfwm_pkg::RFWM_DATA_BITS-1:0]   pwdata,
    output logic [rfwm_pkg::RFWM_DATA_BITS-1:0]   prdata,
    output logic                                  pready,
    output logic [rfwm_pkg::RFWM_FILL_BITS-1:0]   o_limit
);
    import rfwm_pkg::*;

    logic [RFWM_FILL_BITS-1:0] r_limit;
    logic                      sel_limit;

    assign sel_limit = (paddr[2] == 1'b0);
    assign pready    = 1'b1;
    assign o_limit   = r_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (psel && penable && pwrite && sel_limit) begin
            r_limit <= pwdata[RFWM_FILL_BITS-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (sel_limit) begin
            prdata = {{(RFWM_DATA_BITS-RFWM_FILL_BITS){1'b0}}, r_limit};
        end
    end

endmodule

/* sv/rfwm_mem.sv */
// ---------------------------------------------------------------------------
// Ring FIFO entry memory
// One write port and one registered read port with write-to-read bypass.
// ---------------------------------------------------------------------------
module rfwm_mem #(
    parameter int DEPTH = rfwm_pkg::RFWM_DEPTH_DEF,
    parameter int PW    = $clog2(DEPTH)
) (
    input  logic                                       i_clk,
    input  logic                                       i_wr_en,
    input  logic [PW-1:0]                              i_wr_addr,
    input  logic signed [rfwm_pkg::RFWM_WORD_BITS-1:0] i_wr_data,
    input  logic [PW-1:0]                              i_rd_addr,
    output logic signed [rfwm_pkg::RFWM_WORD_BITS-1:0] o_rd_data
);
    import rfwm_pkg::*;

    logic signed [RFWM_WORD_BITS-1:0] r_mem [DEPTH];
    logic signed [RFWM_WORD_BITS-1:0] r_rd_data;

    assign o_rd_data = r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // forward a same-cycle write to the prefetched read
    always_ff @(posedge i_clk) begin
        if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
            r_rd_data <= i_wr_data;
        end else begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

/* sv/rfwm_stats.sv */
// ---------------------------------------------------------------------------
// Ring FIFO reader statistics
// Running minimum, maximum and seen flag for reader A and reader B.
// ---------------------------------------------------------------------------
module rfwm_stats (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rfwm_pkg::t_stat_req   i_req,
    output rfwm_pkg::t_stat_rsp   o_rsp
);
    import rfwm_pkg::*;

    t_stat_rsp r_a;
    t_stat_rsp r_b;
    t_stat_rsp cur;
    t_stat_rsp n_val;

    assign cur = i_req.is_b ? r_b : r_a;

    always_comb begin
        n_val = cur;
        if (i_req.upd) begin
            if (!cur.seen) begin
                n_val.min_val = i_req.value;
                n_val.max_val = i_req.value;
                n_val.seen    = 1'b1;
            end else begin
                if (i_req.value > cur.max_val) begin
                    n_val.max_val = i_req.value;
                end
                if (i_req.value < cur.min_val) begin
                    n_val.min_val = i_req.value;
                end
            end
        end
    end

    assign o_rsp = n_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a <= '0;
            r_b <= '0;
        end else if (i_req.upd) begin
            if (i_req.is_b) begin
                r_b <= n_val;
            end else begin
                r_a <= n_val;
            end
        end
    end

endmodule

/* sv/ring_fifo_with_watermark_minmax_core.sv */
// ---------------------------------------------------------------------------
// Ring FIFO with watermark and reader min/max
// Circular FIFO of signed words with a configurable usable depth.
// ---------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall carry one transaction per item
//   (push, pop by reader A, pop by reader B; action three pops for B).
// Output channel: o_out_valid / i_out_stall carry exactly one result
//   transaction per accepted item, in order.
// Path: an accepted item is held in the input register, and its result is
//   then registered in the result register that drives o_out_valid.
// Throughput: one item per cycle unless the output stalls; the entry memory
//   prefetches the next read word, so back-to-back pops run at full rate.
// A stalled result holds in the result register; the item behind it holds
//   in the input register and o_in_stall rises only once both are full.
// Configuration: buffer_limit at byte address 0 of the APB-style port;
//   write it only while the block is idle.
// Reset: FIFO empty, pointers, high-water mark and reader statistics zero,
//   buffer_limit 50. Entry memory is not cleared and needs no clearing pass.
// ---------------------------------------------------------------------------
module ring_fifo_with_watermark_minmax_core #(
    parameter int DEPTH = rfwm_pkg::RFWM_DEPTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  rfwm_pkg::t_in_item                    i_in_data,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output rfwm_pkg::t_out_item                   o_out_data,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [rfwm_pkg::RFWM_ADDR_BITS-1:0]   paddr,
    input  logic [rfwm_pkg::RFWM_DATA_BITS-1:0]   pwdata,
    output logic [rfwm_pkg::RFWM_DATA_BITS-1:0]   prdata,
    output logic                                  pready
);
    import rfwm_pkg::*;

`include "ring_fifo_with_watermark_minmax_core_assert.svh"

    localparam int PW      = $clog2(DEPTH);
    localparam int AW      = ((PW > RFWM_FILL_BITS) ? PW : RFWM_FILL_BITS) + 1;
    localparam int CAP_INT = (DEPTH > RFWM_FILL_MAX) ? RFWM_FILL_MAX : DEPTH;
    localparam logic [RFWM_FILL_BITS-1:0] DEPTH_CAP = RFWM_FILL_BITS'(CAP_INT);

    function automatic logic [PW-1:0] f_adv(input logic [PW-1:0] p,
                                            input logic [RFWM_FILL_BITS-1:0] lim);
        logic [AW-1:0] n;
        n = AW'(p) + AW'(1);
        if (n >= AW'(lim)) begin
            return '0;
        end
        return n[PW-1:0];
    endfunction

    logic [RFWM_FILL_BITS-1:0] cfg_limit;
    logic [RFWM_FILL_BITS-1:0] eff_limit;

    logic                      r_in_valid;
    t_in_item                  r_in;
    logic                      r_out_valid;
    t_out_item                 r_out;

    logic [PW-1:0]             r_wp;
    logic [PW-1:0]             r_rp;
    logic [RFWM_FILL_BITS-1:0] r_fill;
    logic [RFWM_FILL_BITS-1:0] r_peak;

    logic [PW-1:0]             n_wp;
    logic [PW-1:0]             n_rp;
    logic [RFWM_FILL_BITS-1:0] n_fill;
    logic [RFWM_FILL_BITS-1:0] n_peak;
    t_out_item                 n_out;

    logic                      fire;
    logic                      in_acc;
    logic                      is_push;
    logic                      push_ok;
    logic                      pop_ok;
    logic signed [RFWM_WORD_BITS-1:0] rd_data;
    t_stat_req                 stat_req;
    t_stat_rsp                 stat_rsp;

    rfwm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_limit (cfg_limit)
    );

    always_comb begin
        if (cfg_limit == '0) begin
            eff_limit = RFWM_FILL_BITS'(1);
        end else if (cfg_limit > DEPTH_CAP) begin
            eff_limit = DEPTH_CAP;
        end else begin
            eff_limit = cfg_limit;
        end
    end

    assign fire       = r_in_valid && !(r_out_valid && i_out_stall);
    assign o_in_stall = r_in_valid && !fire;
    assign in_acc     = i_in_valid && !o_in_stall;

    assign is_push = (r_in.action == ACT_PUSH);
    assign push_ok = fire && is_push && (r_fill < eff_limit);
    assign pop_ok  = fire && !is_push && (r_fill != '0);

    assign stat_req.upd   = pop_ok;
    assign stat_req.is_b  = r_in.action[1];
    assign stat_req.value = rd_data;

    rfwm_stats u_stats (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (stat_req),
        .o_rsp   (stat_rsp)
    );

    rfwm_mem #(
        .DEPTH (DEPTH),
        .PW    (PW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (push_ok),
        .i_wr_addr (r_wp),
        .i_wr_data (r_in.push_value),
        .i_rd_addr (n_rp),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_wp   = push_ok ? f_adv(r_wp, eff_limit) : r_wp;
        n_rp   = pop_ok ? f_adv(r_rp, eff_limit) : r_rp;
        n_fill = r_fill;
        if (push_ok) begin
            n_fill = r_fill + RFWM_FILL_BITS'(1);
        end else if (pop_ok) begin
            n_fill = r_fill - RFWM_FILL_BITS'(1);
        end
        n_peak = r_peak;
        if (fire && is_push && (n_fill > r_peak)) begin
            n_peak = n_fill;
        end

        n_out            = '0;
        n_out.occupancy  = n_fill;
        n_out.high_water = n_peak;
        if (is_push) begin
            n_out.status = (r_fill < eff_limit) ? ST_PUSHED : ST_DROPPED;
        end else begin
            n_out.status           = (r_fill != '0) ? ST_POPPED : ST_EMPTY;
            n_out.pop_value        = (r_fill != '0) ? rd_data : '0;
            n_out.reader_min       = stat_rsp.min_val;
            n_out.reader_max       = stat_rsp.max_val;
            n_out.reader_has_value = stat_rsp.seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_wp        <= '0;
            r_rp        <= '0;
            r_fill      <= '0;
            r_peak      <= '0;
        end else begin
            if (in_acc) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            r_wp   <= n_wp;
            r_rp   <= n_rp;
            r_fill <= n_fill;
            r_peak <= n_peak;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_in_data;
        end
        if (fire) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `RFWM_ASSERT_NOW(a_fill_cap, i_clk, i_rst_n, 1'b1, r_fill <= DEPTH_CAP,
        "occupancy above depth")
    `RFWM_ASSERT_NOW(a_peak_ge_fill, i_clk, i_rst_n, 1'b1, r_peak >= r_fill,
        "high-water mark below occupancy")
    `RFWM_ASSERT_NEXT(a_push_incr, i_clk, i_rst_n, push_ok,
        r_fill == $past(r_fill) + RFWM_FILL_BITS'(1), "push did not increment occupancy")
    `RFWM_ASSERT_NEXT(a_empty_pop, i_clk, i_rst_n, fire && !is_push && (r_fill == '0),
        o_out_valid && (o_out_data.status == ST_EMPTY), "empty pop not reported")
    `RFWM_ASSERT_NOW(a_push_no_stats, i_clk, i_rst_n,
        o_out_valid && (o_out_data.status == ST_PUSHED || o_out_data.status == ST_DROPPED),
        !o_out_data.reader_has_value, "push result carries reader statistics")

endmodule
